// ----- design/rrdp_pkg.sv -----
// ----------------------------------------------------------------------------
// rrdp_pkg
// microcode, control word and status types for the run-length dot product
// ----------------------------------------------------------------------------
package rrdp_pkg;

    localparam int STEP_BITS = 3;
    localparam int ACC_BITS  = 64;
    localparam int HALF_BITS = 32;
    localparam int OUT_BITS  = 72;

    typedef logic [STEP_BITS-1:0] step_t;

    localparam step_t STEP_FETCH  = 3'd0;
    localparam step_t STEP_TEST   = 3'd1;
    localparam step_t STEP_ACC_LO = 3'd2;
    localparam step_t STEP_ACC_HI = 3'd3;
    localparam step_t STEP_EMIT   = 3'd4;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_NO_INPUT,
        COND_NO_PAIR,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        logic  take_in;
        logic  mul;
        logic  acc_lo;
        logic  acc_hi;
        logic  emit;
        cond_t cond;
        step_t jump_to;
        step_t fall_to;
    } ctrl_t;

    typedef struct packed {
        logic in_fire;
        logic pair;
        logic out_busy;
    } seq_status_t;

    function automatic ctrl_t ucode(input step_t s);
        ctrl_t c;
        c = '{take_in: 1'b0, mul: 1'b0, acc_lo: 1'b0, acc_hi: 1'b0, emit: 1'b0,
              cond: COND_NONE, jump_to: STEP_FETCH, fall_to: STEP_FETCH};
        case (s)
            STEP_FETCH:
            begin
                c.take_in = 1'b1;
                c.cond    = COND_NO_INPUT;
                c.jump_to = STEP_FETCH;
                c.fall_to = STEP_TEST;
            end
            STEP_TEST:
            begin
                c.mul     = 1'b1;
                c.cond    = COND_NO_PAIR;
                c.jump_to = STEP_EMIT;
                c.fall_to = STEP_ACC_LO;
            end
            STEP_ACC_LO:
            begin
                c.acc_lo  = 1'b1;
                c.jump_to = STEP_ACC_HI;
                c.fall_to = STEP_ACC_HI;
            end
            STEP_ACC_HI:
            begin
                c.acc_hi  = 1'b1;
                c.jump_to = STEP_EMIT;
                c.fall_to = STEP_EMIT;
            end
            STEP_EMIT:
            begin
                c.emit    = 1'b1;
                c.cond    = COND_OUT_BUSY;
                c.jump_to = STEP_EMIT;
                c.fall_to = STEP_FETCH;
            end
            default:
            begin
                c.fall_to = STEP_FETCH;
            end
        endcase
        return c;
    endfunction

endpackage

// ----- design/rle_run_dot_product.sv -----
// ----------------------------------------------------------------------------
// rle_run_dot_product
// dot product of two run-length encoded vectors, one run per request
// ----------------------------------------------------------------------------
// Runs of vectors A and B arrive one per request, tagged by tuser. Each request
// yields one result carrying need_a, need_b, the 64-bit wrapping dot product,
// done and error. A five-step microprogram runs the datapath: a request that does
// not complete a pair of runs passes through fetch, test and emit; when both runs
// are held it also passes through two accumulate steps, which do the 64-bit product
// times overlap as two 32-bit multiply-accumulate steps. A result waiting in the
// output register only holds the sequencer once the next result is due.
module rle_run_dot_product #(
    parameter int VALUE_BITS = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          s_axis_tvalid,
    output logic                                          s_axis_tready,
    // run_value, run_length
    input  logic [((VALUE_BITS+COUNT_BITS+7)/8)*8-1:0]    s_axis_tdata,
    // side
    input  logic                                          s_axis_tuser,
    // last_run
    input  logic                                          s_axis_tlast,
    output logic                                          m_axis_tvalid,
    input  logic                                          m_axis_tready,
    // need_a, need_b, dot_total, done_res, error
    output logic [rrdp_pkg::OUT_BITS-1:0]                 m_axis_tdata
);
    import rrdp_pkg::*;

    localparam int PROD_BITS = 2 * VALUE_BITS;
    localparam int PAD_BITS  = OUT_BITS - ACC_BITS - 4;

    ctrl_t       ctrl;
    seq_status_t status;

    logic signed [VALUE_BITS-1:0] run_value;
    logic        [COUNT_BITS-1:0] run_length;
    logic                         in_fire;
    logic                         load_err;

    logic signed [VALUE_BITS-1:0] a_value_reg, a_value_next;
    logic signed [VALUE_BITS-1:0] b_value_reg, b_value_next;
    logic        [COUNT_BITS-1:0] a_rem_reg, a_rem_next;
    logic        [COUNT_BITS-1:0] b_rem_reg, b_rem_next;
    logic                         a_held_reg, a_held_next;
    logic                         b_held_reg, b_held_next;
    logic                         a_last_reg, a_last_next;
    logic                         b_last_reg, b_last_next;
    logic                         finished_reg, finished_next;
    logic                         pair_reg, pair_next;
    logic                         err_reg, err_next;
    logic        [ACC_BITS-1:0]   acc_reg, acc_next;
    logic        [ACC_BITS-1:0]   prod_reg, prod_next;
    logic        [COUNT_BITS-1:0] ov_reg, ov_next;
    logic                         out_valid_reg, out_valid_next;
    logic        [OUT_BITS-1:0]   out_data_reg, out_data_next;

    logic signed [PROD_BITS-1:0]           vv_prod;
    logic        [COUNT_BITS-1:0]          ov;
    logic        [COUNT_BITS-1:0]          a_left;
    logic        [COUNT_BITS-1:0]          b_left;
    logic        [HALF_BITS+COUNT_BITS-1:0] mul_lo;
    logic        [HALF_BITS-1:0]           mul_hi;
    logic                                  out_busy;

    assign run_value  = s_axis_tdata[VALUE_BITS-1:0];
    assign run_length = s_axis_tdata[VALUE_BITS+COUNT_BITS-1:VALUE_BITS];

    assign s_axis_tready = ctrl.take_in;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_busy      = out_valid_reg && !m_axis_tready;

    assign status = '{in_fire: in_fire, pair: pair_reg, out_busy: out_busy};

    rrdp_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    assign load_err = finished_reg || (s_axis_tuser ? b_held_reg : a_held_reg);
    assign vv_prod  = a_value_reg * b_value_reg;
    assign ov       = (a_rem_reg < b_rem_reg) ? a_rem_reg : b_rem_reg;
    assign a_left   = a_rem_reg - ov;
    assign b_left   = b_rem_reg - ov;
    assign mul_lo   = prod_reg[HALF_BITS-1:0] * ov_reg;
    assign mul_hi   = prod_reg[ACC_BITS-1:HALF_BITS] * ov_reg;

    always_comb
    begin
        a_value_next   = a_value_reg;
        b_value_next   = b_value_reg;
        a_rem_next     = a_rem_reg;
        b_rem_next     = b_rem_reg;
        a_held_next    = a_held_reg;
        b_held_next    = b_held_reg;
        a_last_next    = a_last_reg;
        b_last_next    = b_last_reg;
        finished_next  = finished_reg;
        pair_next      = pair_reg;
        err_next       = err_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        ov_next        = ov_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        // slot load on an accepted request
        if (in_fire)
        begin
            err_next  = load_err;
            pair_next = !load_err && (s_axis_tuser ? a_held_reg : b_held_reg);
            if (!load_err)
            begin
                if (!s_axis_tuser)
                begin
                    a_value_next = run_value;
                    a_rem_next   = run_length;
                    a_last_next  = s_axis_tlast;
                    a_held_next  = 1'b1;
                end
                else
                begin
                    b_value_next = run_value;
                    b_rem_next   = run_length;
                    b_last_next  = s_axis_tlast;
                    b_held_next  = 1'b1;
                end
            end
        end

        // overlap, product of values and slot release
        if (ctrl.mul && pair_reg)
        begin
            prod_next  = ACC_BITS'(vv_prod);
            ov_next    = ov;
            a_rem_next = a_left;
            b_rem_next = b_left;
            if (a_left == '0)
            begin
                a_held_next = 1'b0;
                if (a_last_reg)
                begin
                    finished_next = 1'b1;
                end
            end
            if (b_left == '0)
            begin
                b_held_next = 1'b0;
                if (b_last_reg)
                begin
                    finished_next = 1'b1;
                end
            end
        end

        if (ctrl.acc_lo)
        begin
            acc_next = acc_reg + ACC_BITS'(mul_lo);
        end

        if (ctrl.acc_hi)
        begin
            acc_next = acc_reg + {mul_hi, {HALF_BITS{1'b0}}};
        end

        if (ctrl.emit && !out_busy)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {{PAD_BITS{1'b0}}, err_reg, finished_reg, acc_reg,
                              !b_held_reg && !finished_reg,
                              !a_held_reg && !finished_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_value_reg   <= '0;
            b_value_reg   <= '0;
            a_rem_reg     <= '0;
            b_rem_reg     <= '0;
            a_held_reg    <= 1'b0;
            b_held_reg    <= 1'b0;
            a_last_reg    <= 1'b0;
            b_last_reg    <= 1'b0;
            finished_reg  <= 1'b0;
            pair_reg      <= 1'b0;
            err_reg       <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_value_reg   <= a_value_next;
            b_value_reg   <= b_value_next;
            a_rem_reg     <= a_rem_next;
            b_rem_reg     <= b_rem_next;
            a_held_reg    <= a_held_next;
            b_held_reg    <= b_held_next;
            a_last_reg    <= a_last_next;
            b_last_reg    <= b_last_next;
            finished_reg  <= finished_next;
            pair_reg      <= pair_next;
            err_reg       <= err_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        ov_reg       <= ov_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ----- design/rrdp_seq.sv -----
// ----------------------------------------------------------------------------
// rrdp_seq
// step counter and microcode rom with conditional jumps
// ----------------------------------------------------------------------------
module rrdp_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rrdp_pkg::seq_status_t status,
    output rrdp_pkg::ctrl_t      ctrl
);
    import rrdp_pkg::*;

    step_t step_reg;
    step_t step_next;
    logic  jump;

    always_comb
    begin
        ctrl = ucode(step_reg);
        case (ctrl.cond)
            COND_NONE:     jump = 1'b0;
            COND_NO_INPUT: jump = !status.in_fire;
            COND_NO_PAIR:  jump = !status.pair;
            COND_OUT_BUSY: jump = status.out_busy;
            default:       jump = 1'b0;
        endcase
        step_next = jump ? ctrl.jump_to : ctrl.fall_to;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_FETCH;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule
